[rtl/core/srde_pkg.sv]
// ----------------------------------------------------------------------------
// srde_pkg
// Shared constants, codes and controller/datapath handshake types for the
// signed radix digit emitter.
// ----------------------------------------------------------------------------
package srde_pkg;

    localparam int MAX_BASE_DEF = 64;
    localparam int MAX_DIGITS   = 32;

    localparam int CFG_W  = 7;
    localparam int IDX_W  = 6;
    localparam int CHAR_W = 8;
    localparam int NUM_W  = 32;

    // divider retires this many quotient bits per cycle
    localparam int DIV_BITS   = 8;
    localparam int DIV_CYCLES = NUM_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam int DEPTH_W = $clog2(MAX_DIGITS + 1);
    localparam int STK_AW  = $clog2(MAX_DIGITS);

    localparam logic [CHAR_W-1:0] SIGN_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] PLUS_CHAR = 8'h2B;
    localparam logic [CHAR_W-1:0] NUL_CHAR  = 8'h00;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    typedef struct packed {
        logic load_we;
        logic start;
        logic scan;
        logic sign_out;
        logic div;
        logic pop;
        logic fill;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_end;
        logic base_bad;
        logic neg;
        logic div_last;
        logic quo_done;
        logic out_free;
        logic fill_last;
    } t_dp_sts;

endpackage

[rtl/core/srde_in_if.sv]
// ----------------------------------------------------------------------------
// srde_in_if
// Input channel: symbol load and number convert transactions.
// ----------------------------------------------------------------------------
interface srde_in_if;

    logic               valid;
    logic               ready;
    logic               opcode;
    logic [5:0]         symbol_index;
    logic [7:0]         symbol_char;
    logic signed [31:0] number;

    modport source (
        output valid,
        output opcode,
        output symbol_index,
        output symbol_char,
        output number,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  symbol_index,
        input  symbol_char,
        input  number,
        output ready
    );

endinterface

[rtl/core/srde_out_if.sv]
// ----------------------------------------------------------------------------
// srde_out_if
// Output channel: one emitted character per transaction.
// ----------------------------------------------------------------------------
interface srde_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (
        output valid,
        output out_char,
        output last_char,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_char,
        input  last_char,
        output ready
    );

endinterface

[rtl/core/srde_datapath.sv]
// ----------------------------------------------------------------------------
// srde_datapath
// Symbol table, base check, radix divider, digit stack and output register.
// ----------------------------------------------------------------------------
module srde_datapath import srde_pkg::*; #(
    parameter int MAX_BASE = MAX_BASE_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  logic [IDX_W-1:0]        i_symbol_index,
    input  logic [CHAR_W-1:0]       i_symbol_char,
    input  logic signed [NUM_W-1:0] i_number,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [CHAR_W-1:0]       o_out_char,
    output logic                    o_out_last
);

    localparam int AW = $clog2(MAX_BASE);

    logic [CHAR_W-1:0]   r_tab [MAX_BASE];
    logic [CHAR_W-1:0]   r_rd_data;
    logic [AW-1:0]       r_stk [MAX_DIGITS];

    logic [CFG_W-1:0]    r_len;
    logic [CFG_W-1:0]    r_scan_cnt;
    logic                r_chk_vld;
    logic                r_bad;
    logic [255:0]        r_seen;
    logic                r_neg;
    logic [NUM_W-1:0]    r_mag;
    logic [CFG_W-1:0]    r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [DEPTH_W-1:0]  r_depth;
    logic                r_pop_last;
    logic                r_out_vld;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_last;

    logic [NUM_W-1:0]    n_mag;
    logic [CFG_W-1:0]    n_rem;
    logic [DEPTH_W-1:0]  n_depth_dn;

    logic                tab_we;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                len_ok;
    logic                scan_issue;
    logic                chk_bad;
    logic [NUM_W-1:0]    num_u;
    logic [NUM_W-1:0]    num_mag;
    logic [CFG_W-1:0]    rem;
    logic [CFG_W:0]      trial;
    logic [DIV_BITS-1:0] qbits;
    logic                div_last;

    assign tab_we     = i_cmd.load_we && (32'(i_symbol_index) < MAX_BASE);
    assign len_ok     = (r_len >= CFG_W'(2)) && (32'(r_len) <= MAX_BASE);
    assign scan_issue = len_ok && (r_scan_cnt < r_len);
    assign chk_bad    = (r_rd_data == NUL_CHAR) || (r_rd_data == SIGN_CHAR) ||
                        (r_rd_data == PLUS_CHAR) || r_seen[r_rd_data];
    assign n_depth_dn = r_depth - DEPTH_W'(1);
    assign rd_en      = i_cmd.pop || (i_cmd.scan && scan_issue);
    assign rd_addr    = i_cmd.pop ? r_stk[n_depth_dn[STK_AW-1:0]] : AW'(r_scan_cnt);
    assign div_last   = (r_div_cnt == DIV_CNT_W'(DIV_CYCLES - 1));
    assign num_u      = $unsigned(i_number);
    assign num_mag    = num_u[NUM_W-1] ? (~num_u + NUM_W'(1)) : num_u;

    // restoring division, one byte of quotient per cycle
    always_comb begin
        rem   = (r_div_cnt == '0) ? '0 : r_rem;
        trial = '0;
        qbits = '0;
        for (int i = DIV_BITS - 1; i >= 0; i--) begin
            trial = {rem, r_mag[NUM_W-DIV_BITS+i]};
            if (trial >= {1'b0, r_len}) begin
                trial    = trial - {1'b0, r_len};
                qbits[i] = 1'b1;
            end
            rem = trial[CFG_W-1:0];
        end
        n_rem = rem;
        n_mag = {r_mag[NUM_W-DIV_BITS-1:0], qbits};
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab[AW'(i_symbol_index)] <= i_symbol_char;
        end
        if (rd_en) begin
            r_rd_data <= r_tab[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            r_chk_vld <= i_cmd.scan && scan_issue;
            if (i_cmd.sign_out || i_cmd.fill) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_scan_cnt <= '0;
            r_seen     <= '0;
            r_bad      <= !len_ok;
            r_neg      <= i_number[NUM_W-1];
            r_mag      <= num_mag;
            r_div_cnt  <= '0;
            r_depth    <= '0;
        end
        if (i_cmd.scan) begin
            if (scan_issue) begin
                r_scan_cnt <= r_scan_cnt + CFG_W'(1);
            end
            if (r_chk_vld) begin
                if (chk_bad) begin
                    r_bad <= 1'b1;
                end
                r_seen[r_rd_data] <= 1'b1;
            end
        end
        if (i_cmd.div) begin
            r_mag     <= n_mag;
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            if (div_last) begin
                r_stk[r_depth[STK_AW-1:0]] <= AW'(n_rem);
                r_depth                    <= r_depth + DEPTH_W'(1);
            end
        end
        if (i_cmd.pop) begin
            r_depth    <= n_depth_dn;
            r_pop_last <= (n_depth_dn == '0);
        end
        if (i_cmd.sign_out) begin
            r_out_char <= SIGN_CHAR;
            r_out_last <= 1'b0;
        end else if (i_cmd.fill) begin
            r_out_char <= r_rd_data;
            r_out_last <= r_pop_last;
        end
    end

    always_comb begin
        o_sts.scan_end  = !len_ok || (!scan_issue && !r_chk_vld);
        o_sts.base_bad  = r_bad;
        o_sts.neg       = r_neg;
        o_sts.div_last  = div_last;
        o_sts.quo_done  = (n_mag == '0) || (r_depth == DEPTH_W'(MAX_DIGITS - 1));
        o_sts.out_free  = !r_out_vld || i_out_ready;
        o_sts.fill_last = r_pop_last;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

`ifndef SYNTHESIS
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_depth != '0))
        else $error("digit stack popped while empty");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div && div_last) |-> (r_depth < DEPTH_W'(MAX_DIGITS)))
        else $error("digit stack pushed while full");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sign_out || i_cmd.fill) |-> (!r_out_vld || i_out_ready))
        else $error("output register overwritten before transaction");

    a_read_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_vld |-> $past(rd_en))
        else $error("symbol checked without a table read");
`endif

endmodule

[rtl/core/srde_ctrl.sv]
// ----------------------------------------------------------------------------
// srde_ctrl
// Sequencer for load, base check, division and character emission.
// ----------------------------------------------------------------------------
module srde_ctrl import srde_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_opcode,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_SIGN = 6'b000100,
        S_DIV  = 6'b001000,
        S_POP  = 6'b010000,
        S_FILL = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_opcode == OP_LOAD) begin
                        o_cmd.load_we = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_end) begin
                    priority if (i_sts.base_bad) begin
                        n_state = S_IDLE;
                    end else if (i_sts.neg) begin
                        n_state = S_SIGN;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.sign_out = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last && i_sts.quo_done) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_FILL;
            end
            S_FILL: begin
                if (i_sts.out_free) begin
                    o_cmd.fill = 1'b1;
                    n_state    = i_sts.fill_last ? S_IDLE : S_POP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_cmd_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command at once");

    a_fill_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> ($past(r_state) == S_POP || $past(r_state) == S_FILL))
        else $error("fill reached without a pop");

    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |->
            ($past(r_state) == S_SCAN || $past(r_state) == S_SIGN ||
             $past(r_state) == S_DIV))
        else $error("division entered from an unexpected state");
`endif

endmodule

[rtl/core/signed_radix_digit_emitter.sv]
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter
// Writes a signed 32-bit number as text in a loadable base of symbols.
// ----------------------------------------------------------------------------
//  channel   direction  transaction
//  i_in      in         opcode 0: load symbol_char at symbol_index
//                       opcode 1: convert number
//  o_out     out        one out_char, last_char on the final one
//  i_cfg     in         base_length write, no read-back
//
//  load: a single table write. convert: a symbol check over base_length entries,
//  skipped when base_length is out of range, then the 8-bit-per-cycle radix
//  divider for each digit, a digit stack pop and symbol table read for each
//  character, plus a sign character for a negative number.
//  a new transaction is taken only once the previous convert has emitted
//  its last character into the output register or has rejected its base.
//  output stalls hold the sequencer; reset is synchronous, active low.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter import srde_pkg::*; #(
    parameter int MAX_BASE = MAX_BASE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    srde_in_if.sink          i_in,
    srde_out_if.source       o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    srde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .o_in_ready  (i_in.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    srde_datapath #(
        .MAX_BASE (MAX_BASE)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_symbol_index (i_in.symbol_index),
        .i_symbol_char  (i_in.symbol_char),
        .i_number       (i_in.number),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_out_char     (o_out.out_char),
        .o_out_last     (o_out.last_char)
    );

endmodule

[sim/srde_text_checker.sv]
// ----------------------------------------------------------------------------
// srde_text_checker
// Watches the input, output and base_length configuration of the signed
// radix digit emitter. It keeps its own copy of the symbol table and of the
// radix. For every accepted convert transaction it predicts the characters
// to be emitted. Each output transaction is compared in order with the
// oldest predicted character.
// ----------------------------------------------------------------------------
module srde_text_checker import srde_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    srde_in_if               i_in_mon,
    srde_out_if              i_out_mon,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_chars_checked
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    logic [CHAR_W-1:0] symbols [MAX_BASE_DEF];
    logic [CFG_W-1:0]  radix = '0;
    t_text_char        expected_text [$];
    int                fails = 0;
    int                checked = 0;

    function automatic bit radix_usable();
        int a;
        int b;
        if (radix < 2 || radix > MAX_BASE_DEF) return 1'b0;
        for (a = 0; a < radix; a++) begin
            if (symbols[a] == NUL_CHAR || symbols[a] == SIGN_CHAR ||
                symbols[a] == PLUS_CHAR) return 1'b0;
            for (b = a + 1; b < radix; b++)
                if (symbols[b] == symbols[a]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_text(input logic [NUM_W-1:0] value);
        logic [NUM_W-1:0] mag;
        logic [NUM_W-1:0] divisor;
        logic [IDX_W-1:0] digits [MAX_DIGITS];
        t_text_char       c;
        int               depth;
        depth = 0;
        divisor = NUM_W'(radix);
        if (!radix_usable()) return;
        if (value == '0) begin
            c.ch = symbols[0];
            c.last = 1'b1;
            expected_text.push_back(c);
            return;
        end
        if (value[NUM_W-1]) begin
            c.ch = SIGN_CHAR;
            c.last = 1'b0;
            expected_text.push_back(c);
            // magnitude at 32 bits unsigned, so the most negative value works
            mag = ~value + 1'b1;
        end else begin
            mag = value;
        end
        while (mag != '0 && depth < MAX_DIGITS) begin
            digits[depth] = IDX_W'(mag % divisor);
            mag = mag / divisor;
            depth++;
        end
        while (depth > 0) begin
            depth--;
            c.ch = symbols[digits[depth]];
            c.last = (depth == 0);
            expected_text.push_back(c);
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        if (!i_rst_n) begin
            radix = '0;
            expected_text.delete();
        end else begin
            // compare first so a transaction accepted at this edge queues behind
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_text.size() == 0) begin
                    $error("out_char: expected nothing, got %h (last_char %b)",
                           i_out_mon.out_char, i_out_mon.last_char);
                    fails++;
                end else begin
                    want = expected_text.pop_front();
                    if (i_out_mon.out_char !== want.ch) begin
                        $error("out_char: expected %h, got %h", want.ch,
                               i_out_mon.out_char);
                        fails++;
                    end
                    if (i_out_mon.last_char !== want.last) begin
                        $error("last_char: expected %b, got %b", want.last,
                               i_out_mon.last_char);
                        fails++;
                    end
                    checked++;
                end
            end
            if (i_cfg_we) radix = i_cfg_wdata;
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (i_in_mon.opcode == OP_LOAD)
                    symbols[i_in_mon.symbol_index] = i_in_mon.symbol_char;
                else
                    predict_text(i_in_mon.number);
            end
        end
        o_fail_count    <= fails;
        o_pending       <= expected_text.size();
        o_chars_checked <= checked;
    end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench top for the signed radix digit emitter. It first runs a short
// directed sequence over the base rules, zero, the sign and the extremes. It
// then runs random phases. Each phase loads a base, which may be sound or
// flawed, sets base_length and converts random numbers. Both channels idle
// at random. The checker does the prediction and the comparison.
// ----------------------------------------------------------------------------
module tb;
    import srde_pkg::*;

    localparam int SETTLE_CYCLES  = 256;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEM_TARGET    = 260;

    typedef enum int {
        FLAW_NONE,
        FLAW_DUP,
        FLAW_SIGN,
        FLAW_PLUS,
        FLAW_NUL
    } t_base_flaw;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    int fail_count;
    int pending;
    int chars_checked;
    int idle_cycles = 0;
    int item_count = 0;
    int load_count = 0;
    int convert_count = 0;
    int base_count = 0;
    int cur_len = 0;
    bit calm = 1'b0;

    srde_in_if  in_ch ();
    srde_out_if out_ch ();

    signed_radix_digit_emitter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    srde_text_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_mon        (in_ch),
        .i_out_mon       (out_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_chars_checked (chars_checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [CHAR_W-1:0] ch, input int num);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= op;
        in_ch.symbol_index <= idx;
        in_ch.symbol_char  <= ch;
        in_ch.number       <= num;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        item_count++;
    endtask

    task automatic load_symbol(input int idx, input logic [CHAR_W-1:0] ch);
        send_item(OP_LOAD, IDX_W'(idx), ch, $urandom);
        load_count++;
    endtask

    task automatic convert(input int num);
        send_item(OP_CONVERT, IDX_W'($urandom), CHAR_W'($urandom), num);
        convert_count++;
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // a load or a rejected convert leaves nothing to wait on, so settle too
    task automatic write_base_length(input int len);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(len);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_len = len;
        base_count++;
    endtask

    task automatic load_base(input int len, input t_base_flaw flaw);
        bit                used [256];
        logic [CHAR_W-1:0] sym [MAX_BASE_DEF];
        logic [CHAR_W-1:0] c;
        int                n;
        int                pos;
        bit                reverse;
        if (len > MAX_BASE_DEF) n = MAX_BASE_DEF;
        else if (len < 2) n = $urandom_range(0, 3);
        else n = len;
        reverse = $urandom_range(0, 1);
        used[NUL_CHAR]  = 1'b1;
        used[SIGN_CHAR] = 1'b1;
        used[PLUS_CHAR] = 1'b1;
        for (int i = 0; i < n; i++) begin
            do begin
                c = CHAR_W'($urandom);
            end while (used[c]);
            used[c] = 1'b1;
            sym[i] = c;
        end
        if (n >= 2 && flaw != FLAW_NONE) begin
            pos = $urandom_range(0, n - 1);
            case (flaw)
                FLAW_DUP:  sym[pos] = sym[(pos + 1 + $urandom_range(0, n - 2)) % n];
                FLAW_SIGN: sym[pos] = SIGN_CHAR;
                FLAW_PLUS: sym[pos] = PLUS_CHAR;
                default:   sym[pos] = NUL_CHAR;
            endcase
        end
        for (int i = 0; i < n; i++) begin
            pos = reverse ? n - 1 - i : i;
            load_symbol(pos, sym[pos]);
        end
    endtask

    function automatic int pick_number(input int len);
        int v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 999);
            1: v = -$urandom_range(1, 999);
            2: begin
                case ($urandom_range(0, 7))
                    0: v = 0;
                    1: v = 1;
                    2: v = -1;
                    3: v = 32'h7FFF_FFFF;
                    4: v = 32'h8000_0000;
                    5: v = 32'h8000_0001;
                    6: v = len;
                    default: v = -len;
                endcase
            end
            3: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial begin
        int         len;
        int         n_conv;
        t_base_flaw flaw;
        bit         paused;
        int         phase;
        paused = 1'b0;
        phase = 0;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.opcode       <= OP_LOAD;
        in_ch.symbol_index <= '0;
        in_ch.symbol_char  <= '0;
        in_ch.number       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // decimal digits, then the base rules against reset length and one
        for (int i = 0; i < 10; i++) load_symbol(i, CHAR_W'("0" + i));
        convert(5);
        write_base_length(1);
        convert(7);
        write_base_length(10);
        convert(0);
        convert(1);
        convert(-1);
        convert(32'h7FFF_FFFF);
        convert(32'h8000_0000);
        // minus, plus, zero byte and a repeated symbol each reject the base
        load_symbol(4, SIGN_CHAR);
        convert(42);
        load_symbol(4, PLUS_CHAR);
        convert(42);
        load_symbol(4, NUL_CHAR);
        convert(42);
        load_symbol(4, "0");
        convert(42);
        load_symbol(4, "4");
        load_symbol(63, 8'hFF);
        convert(-40);
        // binary gives the longest text: sign and 32 digits
        write_base_length(2);
        convert(32'h8000_0000);

        while (item_count < ITEM_TARGET) begin
            calm = ($urandom_range(0, 3) == 0);
            flaw = FLAW_NONE;
            if (phase == 0) begin
                len = MAX_BASE_DEF;
            end else if (phase == 1) begin
                len = 127;
            end else begin
                case ($urandom_range(0, 9))
                    6: len = 2;
                    7: begin
                        len = $urandom_range(3, MAX_BASE_DEF);
                        flaw = t_base_flaw'($urandom_range(FLAW_DUP, FLAW_NUL));
                    end
                    8: len = $urandom_range(0, 1);
                    9: len = $urandom_range(MAX_BASE_DEF + 1, 127);
                    default: len = $urandom_range(0, 1) ? $urandom_range(2, 16)
                                                         : $urandom_range(2, MAX_BASE_DEF);
                endcase
            end
            load_base(len, flaw);
            write_base_length(len);
            if (len < 2 || len > MAX_BASE_DEF || flaw != FLAW_NONE)
                n_conv = $urandom_range(4, 8);
            else
                n_conv = $urandom_range(15, 35);
            repeat (n_conv) begin
                if ($urandom_range(0, 11) == 0)
                    load_symbol($urandom_range(0, MAX_BASE_DEF - 1), CHAR_W'($urandom));
                else
                    convert(pick_number(cur_len));
                if (!paused && item_count > 150) begin
                    wait_for_results();
                    paused = 1'b1;
                end
            end
            phase++;
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d symbol loads and %0d conversions over %0d base_length writes",
                 load_count, convert_count, base_count);
        $display("%0d characters compared, %0d field mismatches", chars_checked, fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

endmodule
